[sv/pcsu_pkg.sv]
// Shared constants and types for the PCI configuration space shadow unit.
`timescale 1ns / 1ps

package pcsu_pkg;

  // Configuration space geometry. Byte offsets are eight bits wide, so the
  // backing store never holds more than 256 entries.
  localparam int SPACE_BYTES = 256;
  localparam int ADDR_BITS   = 8;
  localparam int STORE_DEPTH = (SPACE_BYTES < (1 << ADDR_BITS)) ? SPACE_BYTES : (1 << ADDR_BITS);
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Field widths of the access and response channels.
  localparam int FUNC_BITS = 3;
  localparam int BYTE_BITS = 8;

  // Opcode values.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Function number that answers accesses.
  localparam logic [FUNC_BITS-1:0] FUNC_ZERO = '0;

  // Command bit that enables memory space decoding.
  localparam int CMD_MEM_ENABLE_BIT = 1;

  // Special byte offsets.
  localparam logic [ADDR_BITS-1:0] ADDR_VENDOR_LO    = 8'h00;
  localparam logic [ADDR_BITS-1:0] ADDR_VENDOR_HI    = 8'h01;
  localparam logic [ADDR_BITS-1:0] ADDR_DEVICE_LO    = 8'h02;
  localparam logic [ADDR_BITS-1:0] ADDR_DEVICE_HI    = 8'h03;
  localparam logic [ADDR_BITS-1:0] ADDR_COMMAND_LO   = 8'h04;
  localparam logic [ADDR_BITS-1:0] ADDR_STATUS_LO    = 8'h06;
  localparam logic [ADDR_BITS-1:0] ADDR_STATUS_HI    = 8'h07;
  localparam logic [ADDR_BITS-1:0] ADDR_REVISION     = 8'h08;
  localparam logic [ADDR_BITS-1:0] ADDR_CLASS_0      = 8'h09;
  localparam logic [ADDR_BITS-1:0] ADDR_CLASS_1      = 8'h0A;
  localparam logic [ADDR_BITS-1:0] ADDR_CLASS_2      = 8'h0B;
  localparam logic [ADDR_BITS-1:0] ADDR_HEADER_TYPE  = 8'h0E;
  localparam logic [ADDR_BITS-1:0] ADDR_BAR0_0       = 8'h10;
  localparam logic [ADDR_BITS-1:0] ADDR_BAR0_1       = 8'h11;
  localparam logic [ADDR_BITS-1:0] ADDR_BAR0_2       = 8'h12;
  localparam logic [ADDR_BITS-1:0] ADDR_BAR0_3       = 8'h13;
  localparam logic [ADDR_BITS-1:0] ADDR_SUBVEN_LO    = 8'h2C;
  localparam logic [ADDR_BITS-1:0] ADDR_SUBVEN_HI    = 8'h2D;
  localparam logic [ADDR_BITS-1:0] ADDR_SUBSYS_LO    = 8'h2E;
  localparam logic [ADDR_BITS-1:0] ADDR_SUBSYS_HI    = 8'h2F;
  localparam logic [ADDR_BITS-1:0] ADDR_ROM_0        = 8'h30;
  localparam logic [ADDR_BITS-1:0] ADDR_ROM_1        = 8'h31;
  localparam logic [ADDR_BITS-1:0] ADDR_ROM_2        = 8'h32;
  localparam logic [ADDR_BITS-1:0] ADDR_ROM_3        = 8'h33;
  localparam logic [ADDR_BITS-1:0] ADDR_INT_PIN      = 8'h3D;

  // Register port geometry: six registers at 4-byte strides.
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_VENDOR_ID    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEVICE_ID    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REVISION_ID  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SUBSYS_VEN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SUBSYS_ID    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INT_PIN      = 3'd5;

  // Identity values supplied by the register port.
  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] device_id;
    logic [7:0]  revision_id;
    logic [15:0] subsystem_vendor_id;
    logic [15:0] subsystem_id;
    logic [7:0]  interrupt_pin;
  } ident_t;

  // Read and write control toward the byte store.
  typedef struct packed {
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [BYTE_BITS-1:0] wr_data;
  } store_ctl_t;

endpackage

[sv/pcsu_if.sv]
// Valid/ready channel interfaces for configuration accesses and responses.
`timescale 1ns / 1ps

interface pcsu_req_if
  import pcsu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [FUNC_BITS-1:0] function_number;
  logic [ADDR_BITS-1:0] byte_address;
  logic [BYTE_BITS-1:0] write_byte;

  modport source (output valid, opcode, function_number, byte_address, write_byte,
                  input ready);
  modport sink (input valid, opcode, function_number, byte_address, write_byte,
                output ready);
endinterface

interface pcsu_rsp_if
  import pcsu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] read_byte;
  logic                 window_active;
  logic [BYTE_BITS-1:0] window_base_high;

  modport source (output valid, read_byte, window_active, window_base_high,
                  input ready);
  modport sink (input valid, read_byte, window_active, window_base_high,
                output ready);
endinterface

[sv/pcsu_cfg_regs.sv]
// APB-style register bank holding the read-only identity values.
`timescale 1ns / 1ps

module pcsu_cfg_regs
  import pcsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output ident_t            ident
);

  logic                 wr_strobe;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite;
  assign reg_idx   = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ident.vendor_id           <= 16'h121A;
      ident.device_id           <= 16'h0001;
      ident.revision_id         <= 8'h02;
      ident.subsystem_vendor_id <= 16'h121A;
      ident.subsystem_id        <= 16'h0001;
      ident.interrupt_pin       <= 8'h01;
    end else if (wr_strobe) begin
      unique case (reg_idx)
        REG_VENDOR_ID:   ident.vendor_id           <= pwdata[15:0];
        REG_DEVICE_ID:   ident.device_id           <= pwdata[15:0];
        REG_REVISION_ID: ident.revision_id         <= pwdata[7:0];
        REG_SUBSYS_VEN:  ident.subsystem_vendor_id <= pwdata[15:0];
        REG_SUBSYS_ID:   ident.subsystem_id        <= pwdata[15:0];
        REG_INT_PIN:     ident.interrupt_pin       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_VENDOR_ID:   prdata = APB_DW'(ident.vendor_id);
      REG_DEVICE_ID:   prdata = APB_DW'(ident.device_id);
      REG_REVISION_ID: prdata = APB_DW'(ident.revision_id);
      REG_SUBSYS_VEN:  prdata = APB_DW'(ident.subsystem_vendor_id);
      REG_SUBSYS_ID:   prdata = APB_DW'(ident.subsystem_id);
      REG_INT_PIN:     prdata = APB_DW'(ident.interrupt_pin);
      default:         prdata = '0;
    endcase
  end

endmodule

[sv/pcsu_store.sv]
// Byte store for configuration space with per-entry written bits and write forwarding.
`timescale 1ns / 1ps

module pcsu_store
  import pcsu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  store_ctl_t           ctl,
  output logic [BYTE_BITS-1:0] stored_byte
);

  logic [BYTE_BITS-1:0]   mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written;
  logic [BYTE_BITS-1:0]   rdata;
  logic [BYTE_BITS-1:0]   fwd_data;
  logic                   fwd_hit;
  logic                   rd_written;
  logic                   same_addr;

  assign same_addr = ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rdata    <= mem[ctl.rd_addr];
      fwd_data <= ctl.wr_data;
    end
  end

  // An entry never written reads as zero; a write landing on the same edge
  // as the read is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        written[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_written <= written[ctl.rd_addr] || same_addr;
        fwd_hit    <= same_addr;
      end
    end
  end

  assign stored_byte = !rd_written ? '0 : (fwd_hit ? fwd_data : rdata);

endmodule

[sv/pci_config_space_shadow_unit.sv]
// Top level of the PCI type-0 configuration space shadow for function 0.
`timescale 1ns / 1ps

// Byte-wide PCI type-0 configuration space. Each transfer on req is one read
// or write of one byte; each produces exactly one transfer on rsp, in order.
// One access is taken every cycle unless a stalled response holds req off;
// each access passes through the access register and then the response
// register, which presents it on rsp. The read of the 256-entry byte store
// is registered: it is issued on the edge that takes the access into the
// access register, and the response register captures the finished byte
// when the access register advances. Read-modify-write
// of the status bytes and back-to-back accesses to one offset are handled by
// forwarding the byte written on the same edge. Every store entry carries a
// written bit cleared by reset, so no clearing pass is needed and the block
// takes accesses from the first cycle after reset. Identity bytes (vendor,
// device, revision, subsystem ids, interrupt pin) come from the APB registers;
// class code and header type read zero; status bytes are write-one-to-clear;
// BAR0 low bytes and the expansion ROM BAR stay zero. BAR0 top byte sets the
// 16 MB window base, and command bit 1 enables it. Function numbers other
// than zero read zero and leave state untouched.

module pci_config_space_shadow_unit
  import pcsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  pcsu_req_if.sink          req,
  pcsu_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ident_t     ident;
  store_ctl_t store_ctl;

  // Access register.
  logic                 acc_valid;
  logic                 acc_opcode;
  logic [FUNC_BITS-1:0] acc_func;
  logic [ADDR_BITS-1:0] acc_addr;
  logic [BYTE_BITS-1:0] acc_wdata;

  // Window state.
  logic                 memory_enable;
  logic                 memory_enable_next;
  logic [BYTE_BITS-1:0] base_high_byte;
  logic [BYTE_BITS-1:0] base_high_byte_next;

  logic                 acc_advance;
  logic                 req_take;
  logic [BYTE_BITS-1:0] stored_byte;
  logic                 in_range;
  logic                 read_only;
  logic                 is_func0;
  logic                 store_wr;
  logic [BYTE_BITS-1:0] store_wdata;
  logic [BYTE_BITS-1:0] fetch_byte;
  logic [BYTE_BITS-1:0] read_byte_next;

  pcsu_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ident   (ident)
  );

  // Advance the access register when the response register is free or
  // draining this cycle; take a new access when the access register is empty or moves on.
  assign acc_advance = acc_valid && (!rsp.valid || rsp.ready);
  assign req.ready   = !acc_valid || acc_advance;
  assign req_take    = req.valid && req.ready;

  assign store_ctl.rd_en   = req_take;
  assign store_ctl.rd_addr = req.byte_address[STORE_AW-1:0];
  assign store_ctl.wr_en   = acc_advance && store_wr;
  assign store_ctl.wr_addr = acc_addr[STORE_AW-1:0];
  assign store_ctl.wr_data = store_wdata;

  pcsu_store u_store (
    .clk         (clk),
    .rst         (rst),
    .ctl         (store_ctl),
    .stored_byte (stored_byte)
  );

  assign in_range = 32'(acc_addr) < SPACE_BYTES;
  assign is_func0 = acc_func == FUNC_ZERO;

  // Identity, class code and header type bytes never take writes.
  always_comb begin
    case (acc_addr) inside
      ADDR_VENDOR_LO, ADDR_VENDOR_HI, ADDR_DEVICE_LO, ADDR_DEVICE_HI,
      ADDR_REVISION, ADDR_CLASS_0, ADDR_CLASS_1, ADDR_CLASS_2, ADDR_HEADER_TYPE,
      ADDR_SUBVEN_LO, ADDR_SUBVEN_HI, ADDR_SUBSYS_LO, ADDR_SUBSYS_HI,
      ADDR_INT_PIN: read_only = 1'b1;
      default:      read_only = 1'b0;
    endcase
  end

  // Read path: identity bytes from the registers, class code and header type as zero, the rest from the store.
  always_comb begin
    case (acc_addr) inside
      ADDR_VENDOR_LO:   fetch_byte = ident.vendor_id[7:0];
      ADDR_VENDOR_HI:   fetch_byte = ident.vendor_id[15:8];
      ADDR_DEVICE_LO:   fetch_byte = ident.device_id[7:0];
      ADDR_DEVICE_HI:   fetch_byte = ident.device_id[15:8];
      ADDR_REVISION:    fetch_byte = ident.revision_id;
      ADDR_CLASS_0, ADDR_CLASS_1, ADDR_CLASS_2,
      ADDR_HEADER_TYPE: fetch_byte = '0;
      ADDR_SUBVEN_LO:   fetch_byte = ident.subsystem_vendor_id[7:0];
      ADDR_SUBVEN_HI:   fetch_byte = ident.subsystem_vendor_id[15:8];
      ADDR_SUBSYS_LO:   fetch_byte = ident.subsystem_id[7:0];
      ADDR_SUBSYS_HI:   fetch_byte = ident.subsystem_id[15:8];
      ADDR_INT_PIN:     fetch_byte = ident.interrupt_pin;
      default:          fetch_byte = in_range ? stored_byte : '0;
    endcase
  end

  // Write path: apply the per-offset write rule and update the window state.
  always_comb begin
    store_wr            = (acc_opcode == OP_WRITE) && is_func0 && !read_only && in_range;
    store_wdata         = acc_wdata;
    memory_enable_next  = memory_enable;
    base_high_byte_next = base_high_byte;
    case (acc_addr) inside
      ADDR_COMMAND_LO: begin
        if (store_wr) begin
          memory_enable_next = acc_wdata[CMD_MEM_ENABLE_BIT];
        end
      end
      ADDR_STATUS_LO, ADDR_STATUS_HI: begin
        // Write-one-to-clear.
        store_wdata = stored_byte & ~acc_wdata;
      end
      ADDR_BAR0_0, ADDR_BAR0_1, ADDR_BAR0_2,
      ADDR_ROM_0, ADDR_ROM_1, ADDR_ROM_2, ADDR_ROM_3: begin
        store_wdata = '0;
      end
      ADDR_BAR0_3: begin
        if (store_wr) begin
          base_high_byte_next = acc_wdata;
        end
      end
      default: ;
    endcase
  end

  assign read_byte_next = ((acc_opcode == OP_READ) && is_func0) ? fetch_byte : '0;

  // Control state: access and response valids, window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid      <= 1'b0;
      rsp.valid      <= 1'b0;
      memory_enable  <= 1'b0;
      base_high_byte <= '0;
    end else begin
      if (req.ready) begin
        acc_valid <= req.valid;
      end
      if (acc_advance) begin
        rsp.valid      <= 1'b1;
        memory_enable  <= memory_enable_next;
        base_high_byte <= base_high_byte_next;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk) begin
    if (req_take) begin
      acc_opcode <= req.opcode;
      acc_func   <= req.function_number;
      acc_addr   <= req.byte_address;
      acc_wdata  <= req.write_byte;
    end
    if (acc_advance) begin
      rsp.read_byte        <= read_byte_next;
      rsp.window_active    <= memory_enable_next && (base_high_byte_next != '0);
      rsp.window_base_high <= base_high_byte_next;
    end
  end

endmodule

[sv/pcsu_checker.sv]
// Port-level checks for the configuration space shadow unit, bound to the top level.
`timescale 1ns / 1ps

module pcsu_checker
  import pcsu_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [BYTE_BITS-1:0] rsp_read_byte,
  input logic                 rsp_window_active,
  input logic [BYTE_BITS-1:0] rsp_window_base_high
);

  // No response is presented right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // An active window always has a nonzero base.
  a_window_base: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_window_active |-> rsp_window_base_high != '0)
    else $error("window active with zero base");

  // A taken access is followed by a presented response on rsp.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> ##1 rsp_valid)
    else $error("response missing two cycles after access transfer");

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte)
      && $stable(rsp_window_active) && $stable(rsp_window_base_high))
    else $error("stalled response changed");

endmodule

bind pci_config_space_shadow_unit pcsu_checker u_pcsu_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_read_byte        (rsp.read_byte),
  .rsp_window_active    (rsp.window_active),
  .rsp_window_base_high (rsp.window_base_high)
);

[sim/testbench.sv]
// Self-checking testbench for the PCI configuration space shadow unit.
`timescale 1ns / 1ps

module testbench;
  import pcsu_pkg::*;

  // Expected content of one response transfer.
  typedef struct packed {
    logic [BYTE_BITS-1:0] read_byte;
    logic                 window_active;
    logic [BYTE_BITS-1:0] window_base_high;
  } cfg_rsp_t;

  // Identity values the block comes out of reset with.
  localparam ident_t RESET_IDENT = '{vendor_id: 16'h121A, device_id: 16'h0001,
                                     revision_id: 8'h02, subsystem_vendor_id: 16'h121A,
                                     subsystem_id: 16'h0001, interrupt_pin: 8'h01};

  localparam logic [ADDR_BITS-1:0] ADDR_LAST = 8'hFF;

  // Offsets with special behavior; random accesses lean on these so that the
  // window, status and hardwired bytes are exercised often.
  localparam logic [ADDR_BITS-1:0] HOT_OFFSETS [0:24] = '{
    ADDR_VENDOR_LO, ADDR_VENDOR_HI, ADDR_DEVICE_LO, ADDR_DEVICE_HI, ADDR_COMMAND_LO,
    ADDR_STATUS_LO, ADDR_STATUS_HI, ADDR_REVISION, ADDR_CLASS_0, ADDR_CLASS_1,
    ADDR_CLASS_2, ADDR_HEADER_TYPE, ADDR_BAR0_0, ADDR_BAR0_1, ADDR_BAR0_2,
    ADDR_BAR0_3, ADDR_SUBVEN_LO, ADDR_SUBVEN_HI, ADDR_SUBSYS_LO, ADDR_SUBSYS_HI,
    ADDR_ROM_0, ADDR_ROM_1, ADDR_ROM_2, ADDR_ROM_3, ADDR_INT_PIN};

  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 270;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_OFF_EVERY = 400;
  localparam int HOLD_OFF_LEN   = 150;

  // Shadow of the configuration space plus the queue of responses it owes.
  class cfg_space_scoreboard;
    logic [BYTE_BITS-1:0] shadow_bytes [SPACE_BYTES];
    logic                 mem_enable;
    logic [BYTE_BITS-1:0] window_base;
    ident_t               ids;
    cfg_rsp_t             owed [$];
    int                   mismatches;

    function new();
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      mem_enable  = 1'b0;
      window_base = '0;
      ids         = RESET_IDENT;
      mismatches  = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function logic [BYTE_BITS-1:0] fetch(logic [ADDR_BITS-1:0] addr);
      case (addr)
        ADDR_VENDOR_LO:   return ids.vendor_id[7:0];
        ADDR_VENDOR_HI:   return ids.vendor_id[15:8];
        ADDR_DEVICE_LO:   return ids.device_id[7:0];
        ADDR_DEVICE_HI:   return ids.device_id[15:8];
        ADDR_REVISION:    return ids.revision_id;
        ADDR_CLASS_0, ADDR_CLASS_1, ADDR_CLASS_2, ADDR_HEADER_TYPE: return '0;
        ADDR_SUBVEN_LO:   return ids.subsystem_vendor_id[7:0];
        ADDR_SUBVEN_HI:   return ids.subsystem_vendor_id[15:8];
        ADDR_SUBSYS_LO:   return ids.subsystem_id[7:0];
        ADDR_SUBSYS_HI:   return ids.subsystem_id[15:8];
        ADDR_INT_PIN:     return ids.interrupt_pin;
        default:          return (int'(addr) < SPACE_BYTES) ? shadow_bytes[addr] : '0;
      endcase
    endfunction

    function void store(logic [ADDR_BITS-1:0] addr, logic [BYTE_BITS-1:0] wb);
      case (addr)
        ADDR_VENDOR_LO, ADDR_VENDOR_HI, ADDR_DEVICE_LO, ADDR_DEVICE_HI, ADDR_REVISION,
        ADDR_CLASS_0, ADDR_CLASS_1, ADDR_CLASS_2, ADDR_HEADER_TYPE,
        ADDR_SUBVEN_LO, ADDR_SUBVEN_HI, ADDR_SUBSYS_LO, ADDR_SUBSYS_HI, ADDR_INT_PIN: ;
        ADDR_COMMAND_LO: begin
          shadow_bytes[addr] = wb;
          mem_enable = wb[CMD_MEM_ENABLE_BIT];
        end
        ADDR_STATUS_LO, ADDR_STATUS_HI: shadow_bytes[addr] = shadow_bytes[addr] & ~wb;
        ADDR_BAR0_0, ADDR_BAR0_1, ADDR_BAR0_2,
        ADDR_ROM_0, ADDR_ROM_1, ADDR_ROM_2, ADDR_ROM_3: shadow_bytes[addr] = '0;
        ADDR_BAR0_3: begin
          shadow_bytes[addr] = wb;
          window_base = wb;
        end
        default: if (int'(addr) < SPACE_BYTES) shadow_bytes[addr] = wb;
      endcase
    endfunction

    function void note_access(logic op, logic [FUNC_BITS-1:0] fn,
                              logic [ADDR_BITS-1:0] addr, logic [BYTE_BITS-1:0] wb);
      cfg_rsp_t r;
      r.read_byte = '0;
      if (fn == FUNC_ZERO) begin
        if (op == OP_READ) r.read_byte = fetch(addr);
        else store(addr, wb);
      end
      r.window_active    = mem_enable && (window_base != '0);
      r.window_base_high = window_base;
      owed.push_back(r);
    endfunction

    function void check_response(logic [BYTE_BITS-1:0] rd, logic act,
                                 logic [BYTE_BITS-1:0] base);
      cfg_rsp_t want;
      if (owed.size() == 0) begin
        $error("response with nothing owed: read_byte %0h", rd);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (rd !== want.read_byte) begin
        $error("read_byte: expected %0h, got %0h", want.read_byte, rd);
        mismatches++;
      end
      if (act !== want.window_active) begin
        $error("window_active: expected %0b, got %0b", want.window_active, act);
        mismatches++;
      end
      if (base !== want.window_base_high) begin
        $error("window_base_high: expected %0h, got %0h", want.window_base_high, base);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  pcsu_req_if req_ch();
  pcsu_rsp_if rsp_ch();

  cfg_space_scoreboard sb = new();

  // Sender side: draw whether the current stretch runs without gaps.
  bit send_quiet;
  int sent_count;

  pci_config_space_shadow_unit uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Write one identity register over APB: setup cycle, then access cycle.
  // Enter and leave at a falling edge.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    // Hold the access phase until the slave signals completion.
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Program all six identity registers and mirror them in the shadow.
  task automatic program_identity(ident_t v);
    write_reg(REG_VENDOR_ID,   {16'h0, v.vendor_id});
    write_reg(REG_DEVICE_ID,   {16'h0, v.device_id});
    write_reg(REG_REVISION_ID, {24'h0, v.revision_id});
    write_reg(REG_SUBSYS_VEN,  {16'h0, v.subsystem_vendor_id});
    write_reg(REG_SUBSYS_ID,   {16'h0, v.subsystem_id});
    write_reg(REG_INT_PIN,     {24'h0, v.interrupt_pin});
    sb.ids = v;
  endtask

  // Offer one access on req. Enter at a falling edge, leave at the falling
  // edge after the transfer with valid still high, so a back-to-back item
  // just overwrites the payload without dropping valid.
  task automatic offer_access(logic op, logic [FUNC_BITS-1:0] fn,
                              logic [ADDR_BITS-1:0] addr, logic [BYTE_BITS-1:0] wb);
    int gap;
    if (sent_count % 50 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid           = 1'b1;
    req_ch.opcode          = op;
    req_ch.function_number = fn;
    req_ch.byte_address    = addr;
    req_ch.write_byte      = wb;
    do @(posedge clk); while (!req_ch.ready);
    // Predict at the accepting edge, in acceptance order.
    sb.note_access(op, fn, addr, wb);
    sent_count++;
    @(negedge clk);
  endtask

  // Drop valid and let every owed response drain before touching registers.
  task automatic settle_idle();
    req_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random access: mostly function 0 and mostly the special offsets or the
  // lower header, so the window and W1C paths see real traffic.
  task automatic offer_random_access();
    logic                 op;
    logic [FUNC_BITS-1:0] fn;
    logic [ADDR_BITS-1:0] addr;
    logic [BYTE_BITS-1:0] wb;
    int                   pick;
    op   = 1'($urandom_range(0, 1));
    fn   = ($urandom_range(0, 4) == 0) ? FUNC_BITS'($urandom_range(1, 7)) : FUNC_ZERO;
    pick = $urandom_range(0, 3);
    if (pick == 0)      addr = ADDR_BITS'($urandom_range(0, 255));
    else if (pick == 1) addr = ADDR_BITS'($urandom_range(0, 63));
    else                addr = HOT_OFFSETS[5'($urandom_range(0, 24))];
    wb = BYTE_BITS'($urandom_range(0, 255));
    offer_access(op, fn, addr, wb);
  endtask

  function automatic ident_t random_identity();
    ident_t v;
    v.vendor_id           = 16'($urandom_range(0, 16'hFFFF));
    v.device_id           = 16'($urandom_range(0, 16'hFFFF));
    v.revision_id         = 8'($urandom_range(0, 8'hFF));
    v.subsystem_vendor_id = 16'($urandom_range(0, 16'hFFFF));
    v.subsystem_id        = 16'($urandom_range(0, 16'hFFFF));
    v.interrupt_pin       = 8'($urandom_range(0, 8'hFF));
    return v;
  endfunction

  // Receiver: draw a stall before each transfer, with quiet stretches, and
  // now and then hold ready low for a long stretch so the block backs up and
  // stalls req while the sender keeps offering.
  initial begin
    int  stall;
    int  got;
    bit  rcv_quiet;
    rsp_ch.ready = 1'b0;
    got       = 0;
    rcv_quiet = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (got % 40 == 0) rcv_quiet = ($urandom_range(0, 3) == 0);
      if (got > 0 && got % HOLD_OFF_EVERY == 0) stall = HOLD_OFF_LEN;
      else stall = rcv_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_response(rsp_ch.read_byte, rsp_ch.window_active, rsp_ch.window_base_high);
      got++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run as failed at the cycle limit, whether or not traffic still progresses.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    ident_t setting;
    rst                    = 1'b1;
    req_ch.valid           = 1'b0;
    req_ch.opcode          = OP_READ;
    req_ch.function_number = FUNC_ZERO;
    req_ch.byte_address    = '0;
    req_ch.write_byte      = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    send_quiet = 1'b0;
    sent_count = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed pass with the reset identity values.
    // Identity bytes read straight from the registers.
    offer_access(OP_READ,  FUNC_ZERO, ADDR_VENDOR_LO, 8'h00);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_VENDOR_HI, 8'h00);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_DEVICE_HI, 8'h00);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_REVISION,  8'h00);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_SUBVEN_HI, 8'h00);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_INT_PIN,   8'h00);
    // Writes to identity and header type bytes are dropped.
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_VENDOR_LO, 8'hFF);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_VENDOR_LO, 8'h00);
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_HEADER_TYPE, 8'hFF);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_HEADER_TYPE, 8'h00);
    // Base first, then memory enable: the window opens on the second write.
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_BAR0_3,    8'hFF);
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_COMMAND_LO, 8'hFF);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_COMMAND_LO, 8'h00);
    // Status is write-one-to-clear.
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_STATUS_LO, 8'hFF);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_STATUS_LO, 8'h00);
    // BAR0 low bytes and the ROM BAR stay zero.
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_BAR0_0,    8'hAB);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_BAR0_0,    8'h00);
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_ROM_0,     8'h5A);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_ROM_3,     8'h00);
    // Other functions read zero and change nothing.
    offer_access(OP_WRITE, 3'd7,      ADDR_BAR0_3,    8'h00);
    offer_access(OP_READ,  3'd7,      ADDR_VENDOR_LO, 8'h00);
    // Top of the space behaves as plain storage.
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_LAST,      8'hFF);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_LAST,      8'h00);
    // Clearing the base closes the window again.
    offer_access(OP_WRITE, FUNC_ZERO, ADDR_BAR0_3,    8'h00);
    offer_access(OP_READ,  FUNC_ZERO, ADDR_BAR0_3,    8'h00);

    // Random phases, each under its own identity setting: all zeros, all
    // ones, then random values.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      if (phase == 0)      setting = '0;
      else if (phase == 1) setting = '1;
      else                 setting = random_identity();
      program_identity(setting);
      for (int i = 0; i < PHASE_ITEMS; i++) offer_random_access();
    end

    // Drain: drop valid, wait for every owed response, then wait longer
    // to catch any stray transfer.
    req_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
